### rtl/core/ilnch_pkg.sv
// Shared types, codes and constants for the igniter launch sequencer.
// Used by every module of the block but the checker; depends on nothing else.

package ilnch_pkg;

	// Field widths.
	localparam int OP_W      = 4;
	localparam int TIME_W    = 48;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int TICK_W    = 32;
	// Widest millisecond value that is ever turned into ticks (lead plus delay).
	localparam int MS_W      = CFG_W + 1;

	// Default tick rate and the rounding term of the ms to tick conversion.
	localparam int TICKS_PER_SECOND_DEF = 1000;
	localparam int ROUND_UP_MS          = 999;

	// Register reset values.
	localparam logic [CFG_W-1:0] START_DELAY_RST  = 16'd5000;
	localparam logic [CFG_W-1:0] LATENCY_COMP_RST = 16'd750;
	localparam logic [CFG_W-1:0] BURN_TIME_RST    = 16'd10000;
	localparam logic [CFG_W-1:0] HOLDOFF_RST      = 16'd1500;
	localparam logic [CFG_W-1:0] MAX_AGE_RST      = 16'd5000;
	localparam logic [CFG_W-1:0] MAX_LEAD_RST     = 16'd1000;

	// Command codes.
	typedef enum logic [OP_W-1:0] {
		OP_TICK      = 4'd0,
		OP_IGN_ON    = 4'd1,
		OP_IGN_OFF   = 4'd2,
		OP_N2_OPEN   = 4'd3,
		OP_N2_CLOSE  = 4'd4,
		OP_N2O_OPEN  = 4'd5,
		OP_N2O_CLOSE = 4'd6,
		OP_RETRACT   = 4'd7,
		OP_SEQUENCE  = 4'd8
	} op_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_DELAY  = 3'd0,
		REG_LATENCY_COMP = 3'd1,
		REG_BURN_TIME    = 3'd2,
		REG_HOLDOFF      = 3'd3,
		REG_MAX_AGE      = 3'd4,
		REG_MAX_LEAD     = 3'd5
	} cfg_reg_t;

	// Control bits of one item, carried down the pipeline.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            abort_latched;
		logic            driver_accepts;
		logic            stepper_started;
		logic            stepper_busy;
	} ctl_t;

	// Registers used by the timestamp compensation stages.
	typedef struct packed {
		logic [CFG_W-1:0] start_delay;
		logic [CFG_W-1:0] latency_comp;
		logic [CFG_W-1:0] max_age;
		logic [CFG_W-1:0] max_lead;
	} comp_cfg_t;

	// One result item.
	typedef struct packed {
		logic igniter_drive;
		logic nitrogen_valve;
		logic nitrous_valve;
		logic retract_done_flag;
		logic stepper_run;
		logic sequence_active;
		logic holdoff_active;
		logic safe_off_event;
	} result_t;

endpackage

### rtl/core/ilnch_ms2tick.sv
// Two-stage millisecond to tick converter: ceil(ms * TICKS_PER_SECOND / 1000), at least 1.
// Depends on ilnch_pkg for widths and the rounding constant.

module ilnch_ms2tick #(
	parameter int TICKS_PER_SECOND = ilnch_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic                          clk,
	input  logic                          en_s1,
	input  logic                          en_s2,
	input  logic [ilnch_pkg::MS_W-1:0]    ms,
	output logic [ilnch_pkg::TICK_W-1:0]  ticks
);

	localparam int TpsW   = $clog2(TICKS_PER_SECOND + 1);
	localparam int ProdW  = ilnch_pkg::MS_W + TpsW + 1;
	// Dividing by 1000 is a shift by 3 followed by a division by 125.
	localparam int NumW   = ProdW - 3;
	localparam int RecipW = NumW + 2;
	localparam int Shift  = NumW + 7;
	localparam int QuoW   = NumW - 5;
	localparam int FullW  = NumW + RecipW;
	localparam logic [63:0] RecipFull = ((64'd1 << Shift) / 64'd125) + 64'd1;
	localparam logic [RecipW-1:0] Recip = RecipFull[RecipW-1:0];

	logic [ProdW-1:0] prod_s1;
	logic [FullW-1:0] full;
	logic [QuoW-1:0]  quo_s2;

	// First stage: scale to ticks and add the round-up term.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s1 <= ProdW'(ms) * ProdW'(TICKS_PER_SECOND) + ProdW'(ilnch_pkg::ROUND_UP_MS);
		end
	end

	// Second stage: exact division by 125 through a reciprocal multiply.
	assign full = FullW'(prod_s1[ProdW-1:3]) * FullW'(Recip);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			quo_s2 <= full[Shift +: QuoW];
		end
	end

	// A zero-length time still takes one tick.
	assign ticks = (quo_s2 == '0) ? ilnch_pkg::TICK_W'(1) : ilnch_pkg::TICK_W'(quo_s2);

endmodule

### rtl/core/ilnch_fire_calc.sv
// Timestamp compensation stages: packet age or lead against the compensated start delay.
// Produces the millisecond offset to convert and a fire-immediately flag. Uses ilnch_pkg.

module ilnch_fire_calc (
	input  logic                          clk,
	input  logic                          en_s2,
	input  logic                          en_s3,
	input  ilnch_pkg::comp_cfg_t          cfg,
	input  logic [ilnch_pkg::TIME_W-1:0]  pkt_s1,
	input  logic [ilnch_pkg::TIME_W-1:0]  wall_s1,
	output logic [ilnch_pkg::MS_W-1:0]    ms_s3,
	output logic                          now_s3
);

	localparam int TW = ilnch_pkg::TIME_W;
	localparam int CW = ilnch_pkg::CFG_W;

	logic [CW-1:0] comp;
	logic [TW:0]   age_s2;
	logic [TW-1:0] lead_s2;
	logic          none_s2;
	logic [CW-1:0] comp_s2;
	logic          age_over;
	logic          lead_over;
	logic [ilnch_pkg::MS_W-1:0] ms_d;
	logic          now_d;

	// Compensated delay, floored at zero.
	assign comp = (cfg.start_delay > cfg.latency_comp) ?
		(cfg.start_delay - cfg.latency_comp) : '0;

	// Age and lead are formed in parallel; the borrow bit tells which one applies.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			age_s2  <= {1'b0, wall_s1} - {1'b0, pkt_s1};
			lead_s2 <= pkt_s1 - wall_s1;
			none_s2 <= (pkt_s1 == '0) || (wall_s1 == '0);
			comp_s2 <= comp;
		end
	end

	assign age_over  = (|age_s2[TW-1:CW]) || (age_s2[CW-1:0] > cfg.max_age);
	assign lead_over = (|lead_s2[TW-1:CW]) || (lead_s2[CW-1:0] > cfg.max_lead);

	// Select the offset: plain delay, shortened by age, lengthened by lead, or fire now.
	always_comb begin
		ms_d  = ilnch_pkg::MS_W'(comp_s2);
		now_d = 1'b0;
		if (!none_s2) begin
			if (!age_s2[TW]) begin
				if (!age_over) begin
					if (age_s2[CW-1:0] >= comp_s2) begin
						now_d = 1'b1;
					end else begin
						ms_d = ilnch_pkg::MS_W'(comp_s2 - age_s2[CW-1:0]);
					end
				end
			end else if (!lead_over) begin
				ms_d = ilnch_pkg::MS_W'(lead_s2[CW-1:0]) + ilnch_pkg::MS_W'(comp_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			ms_s3  <= ms_d;
			now_s3 <= now_d;
		end
	end

endmodule

### rtl/core/ilnch_state.sv
// Sequencer and interlock state with the result register. Uses ilnch_pkg.
// Applies one item per load-enabled cycle to the tick counter, drives and timers.

module ilnch_state (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  ilnch_pkg::ctl_t               ctl,
	input  logic                          fire_now,
	input  logic [ilnch_pkg::TICK_W-1:0]  delay_ticks,
	input  logic [ilnch_pkg::TICK_W-1:0]  burn_ticks,
	input  logic [ilnch_pkg::TICK_W-1:0]  hold_ticks,
	output ilnch_pkg::result_t            result_q
);

	localparam int TW = ilnch_pkg::TICK_W;

	logic [TW-1:0] tick_q, fire_q, stop_q, hold_from_q;
	logic          ign_q, n2_q, n2o_q, retracted_q, run_q, armed_q, burning_q, hold_q;

	logic [TW-1:0] tick_d, fire_d, stop_d, hold_from_d;
	logic          ign_d, n2_d, n2o_d, retracted_d, run_d, armed_d, burning_d, hold_d;
	logic          safe_d;
	logic [TW-1:0] fire_calc, d_fire, d_stop, d_hold;

	// Next state for the item now leaving the pipeline.
	always_comb begin
		tick_d      = (ctl.op == ilnch_pkg::OP_TICK) ? tick_q + TW'(1) : tick_q;
		fire_d      = fire_q;
		stop_d      = stop_q;
		hold_from_d = hold_from_q;
		ign_d       = ign_q;
		n2_d        = n2_q;
		n2o_d       = n2o_q;
		retracted_d = retracted_q;
		run_d       = run_q;
		armed_d     = armed_q;
		burning_d   = burning_q;
		hold_d      = hold_q;
		safe_d      = 1'b0;
		fire_calc   = fire_now ? tick_d : tick_d + delay_ticks;
		d_fire      = tick_d - fire_q;
		d_stop      = '0;
		d_hold      = '0;

		if (ctl.abort_latched) begin
			// Abort forces every drive off; the retract flag stays.
			armed_d   = 1'b0;
			burning_d = 1'b0;
			hold_d    = 1'b0;
			run_d     = 1'b0;
			ign_d     = 1'b0;
			n2_d      = 1'b0;
			n2o_d     = 1'b0;
			safe_d    = 1'b1;
		end else begin
			unique case (ilnch_pkg::op_t'(ctl.op))
				ilnch_pkg::OP_TICK: begin
					// Fire once the fire tick is reached and the driver switches on.
					if (armed_q && !d_fire[TW-1] && ctl.driver_accepts) begin
						ign_d     = 1'b1;
						armed_d   = 1'b0;
						burning_d = 1'b1;
						stop_d    = tick_d + burn_ticks;
					end
					// End of burn starts the holdoff.
					d_stop = tick_d - stop_d;
					if (burning_d && !d_stop[TW-1]) begin
						ign_d       = 1'b0;
						burning_d   = 1'b0;
						hold_d      = 1'b1;
						hold_from_d = tick_d;
					end
					d_hold = tick_d - hold_from_d;
					if (hold_d && (d_hold >= hold_ticks)) begin
						hold_d = 1'b0;
					end
					if (run_q && !ctl.stepper_busy) begin
						run_d = 1'b0;
					end
				end
				ilnch_pkg::OP_IGN_ON: begin
					armed_d   = 1'b0;
					burning_d = 1'b0;
					hold_d    = 1'b0;
					if (ctl.driver_accepts) begin
						ign_d = 1'b1;
					end
				end
				ilnch_pkg::OP_IGN_OFF: begin
					armed_d   = 1'b0;
					burning_d = 1'b0;
					hold_d    = 1'b0;
					ign_d     = 1'b0;
				end
				ilnch_pkg::OP_N2_OPEN: begin
					if (ctl.driver_accepts) begin
						n2_d = 1'b1;
					end
				end
				ilnch_pkg::OP_N2_CLOSE: begin
					n2_d = 1'b0;
				end
				ilnch_pkg::OP_N2O_OPEN: begin
					if (ctl.driver_accepts) begin
						n2o_d = 1'b1;
					end
				end
				ilnch_pkg::OP_N2O_CLOSE: begin
					n2o_d = 1'b0;
				end
				ilnch_pkg::OP_RETRACT: begin
					if (!run_q) begin
						retracted_d = 1'b1;
						if (ctl.stepper_started) begin
							run_d = 1'b1;
						end
					end
				end
				ilnch_pkg::OP_SEQUENCE: begin
					// A new sequence is taken only when nothing is armed, burning or holding off.
					if (!armed_q && !burning_q && !hold_q) begin
						fire_d  = fire_calc;
						stop_d  = fire_calc + burn_ticks;
						armed_d = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			fire_q      <= '0;
			stop_q      <= '0;
			hold_from_q <= '0;
			ign_q       <= 1'b0;
			n2_q        <= 1'b0;
			n2o_q       <= 1'b0;
			retracted_q <= 1'b0;
			run_q       <= 1'b0;
			armed_q     <= 1'b0;
			burning_q   <= 1'b0;
			hold_q      <= 1'b0;
		end else if (load) begin
			tick_q      <= tick_d;
			fire_q      <= fire_d;
			stop_q      <= stop_d;
			hold_from_q <= hold_from_d;
			ign_q       <= ign_d;
			n2_q        <= n2_d;
			n2o_q       <= n2o_d;
			retracted_q <= retracted_d;
			run_q       <= run_d;
			armed_q     <= armed_d;
			burning_q   <= burning_d;
			hold_q      <= hold_d;
		end
	end

	// Result register; payload only, so no reset.
	always_ff @(posedge clk) begin
		if (load) begin
			result_q.igniter_drive     <= ign_d;
			result_q.nitrogen_valve    <= n2_d;
			result_q.nitrous_valve     <= n2o_d;
			result_q.retract_done_flag <= retracted_d;
			result_q.stepper_run       <= run_d;
			result_q.sequence_active   <= armed_d || burning_d;
			result_q.holdoff_active    <= hold_d;
			result_q.safe_off_event    <= safe_d;
		end
	end

endmodule

### rtl/core/igniter_launch_sequencer.sv
// Top level of the igniter launch sequencer: input register, pipeline control,
// configuration registers, converters. Uses ilnch_pkg, all ilnch_* but the checker.
//
// Usage:
//   Items (a tick or a command) arrive on the in_valid/in_ready channel; each one
//   yields exactly one result on the out_valid/out_ready channel, in order.
//   Registers are written on the cfg_valid/cfg_ready channel (cfg_ready is always
//   high); the user must write them only while no item is in flight, as the block
//   does not enforce it. Indexes beyond the last register are dropped.
//   Throughput: one item per cycle while the receiver does not stall; the state
//   update sits at the end of a five-stage pipeline (input, age/lead, offset,
//   scale, divide), so that update alone sets the rate.
//   The burn and holdoff tick counts come from two converters fed by the registers;
//   they settle after a register write, well ahead of any later item's update.
//   Reset clears the tick counter, drives and timers, empties the pipeline and
//   loads the register defaults.
//   When the receiver stalls, the result is held and the stages behind it keep
//   filling; in_ready falls only when every stage holds an item.

module igniter_launch_sequencer #(
	parameter int TICKS_PER_SECOND = ilnch_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ilnch_pkg::OP_W-1:0]       op,
	input  logic                             abort_latched,
	input  logic [ilnch_pkg::TIME_W-1:0]     packet_time_ms,
	input  logic [ilnch_pkg::TIME_W-1:0]     wall_time_ms,
	input  logic                             driver_accepts,
	input  logic                             stepper_started,
	input  logic                             stepper_busy,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ilnch_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ilnch_pkg::CFG_W-1:0]      cfg_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             igniter_drive,
	output logic                             nitrogen_valve,
	output logic                             nitrous_valve,
	output logic                             retract_done_flag,
	output logic                             stepper_run,
	output logic                             sequence_active,
	output logic                             holdoff_active,
	output logic                             safe_off_event
);

	localparam int CW = ilnch_pkg::CFG_W;
	localparam int TW = ilnch_pkg::TICK_W;

	// Configuration registers.
	logic [CW-1:0] start_delay_q, latency_comp_q, burn_time_q, holdoff_q, max_age_q, max_lead_q;

	// Pipeline valids, moves and payload.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic mv1, mv2, mv3, mv4, mv5;
	logic free1, free2, free3, free4, free5, out_free;
	ilnch_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [ilnch_pkg::TIME_W-1:0] pkt_s1, wall_s1;
	logic [ilnch_pkg::MS_W-1:0]   ms_s3;
	logic now_s3, now_s4, now_s5;
	logic [TW-1:0] delay_ticks, burn_ticks, hold_ticks;
	ilnch_pkg::comp_cfg_t comp_cfg;
	ilnch_pkg::result_t   result;

	assign cfg_ready = 1'b1;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delay_q  <= ilnch_pkg::START_DELAY_RST;
			latency_comp_q <= ilnch_pkg::LATENCY_COMP_RST;
			burn_time_q    <= ilnch_pkg::BURN_TIME_RST;
			holdoff_q      <= ilnch_pkg::HOLDOFF_RST;
			max_age_q      <= ilnch_pkg::MAX_AGE_RST;
			max_lead_q     <= ilnch_pkg::MAX_LEAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ilnch_pkg::cfg_reg_t'(cfg_index))
				ilnch_pkg::REG_START_DELAY:  start_delay_q  <= cfg_data;
				ilnch_pkg::REG_LATENCY_COMP: latency_comp_q <= cfg_data;
				ilnch_pkg::REG_BURN_TIME:    burn_time_q    <= cfg_data;
				ilnch_pkg::REG_HOLDOFF:      holdoff_q      <= cfg_data;
				ilnch_pkg::REG_MAX_AGE:      max_age_q      <= cfg_data;
				ilnch_pkg::REG_MAX_LEAD:     max_lead_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign comp_cfg.start_delay  = start_delay_q;
	assign comp_cfg.latency_comp = latency_comp_q;
	assign comp_cfg.max_age      = max_age_q;
	assign comp_cfg.max_lead     = max_lead_q;

	// Stage advance: a stage moves on when the one below is empty or moving.
	assign out_free = !out_valid_q || out_ready;
	assign mv5      = v_s5 && out_free;
	assign free5    = !v_s5 || mv5;
	assign mv4      = v_s4 && free5;
	assign free4    = !v_s4 || mv4;
	assign mv3      = v_s3 && free4;
	assign free3    = !v_s3 || mv3;
	assign mv2      = v_s2 && free3;
	assign free2    = !v_s2 || mv2;
	assign mv1      = v_s1 && free2;
	assign free1    = !v_s1 || mv1;
	assign in_ready = free1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free1)    v_s1        <= in_valid;
			if (free2)    v_s2        <= v_s1;
			if (free3)    v_s3        <= v_s2;
			if (free4)    v_s4        <= v_s3;
			if (free5)    v_s5        <= v_s4;
			if (out_free) out_valid_q <= v_s5;
		end
	end

	// Input register and control bits carried alongside the compute stages.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ctl_s1.op              <= op;
			ctl_s1.abort_latched   <= abort_latched;
			ctl_s1.driver_accepts  <= driver_accepts;
			ctl_s1.stepper_started <= stepper_started;
			ctl_s1.stepper_busy    <= stepper_busy;
			pkt_s1                 <= packet_time_ms;
			wall_s1                <= wall_time_ms;
		end
		if (mv1) ctl_s2 <= ctl_s1;
		if (mv2) ctl_s3 <= ctl_s2;
		if (mv3) begin
			ctl_s4 <= ctl_s3;
			now_s4 <= now_s3;
		end
		if (mv4) begin
			ctl_s5 <= ctl_s4;
			now_s5 <= now_s4;
		end
	end

	ilnch_fire_calc u_fire_calc (
		.clk     (clk),
		.en_s2   (mv1),
		.en_s3   (mv2),
		.cfg     (comp_cfg),
		.pkt_s1  (pkt_s1),
		.wall_s1 (wall_s1),
		.ms_s3   (ms_s3),
		.now_s3  (now_s3)
	);

	// Per-item offset conversion, in step with stages four and five.
	ilnch_ms2tick #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_delay_conv (
		.clk   (clk),
		.en_s1 (mv3),
		.en_s2 (mv4),
		.ms    (ms_s3),
		.ticks (delay_ticks)
	);

	// Burn and holdoff conversions run freely off the registers.
	ilnch_ms2tick #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_burn_conv (
		.clk   (clk),
		.en_s1 (1'b1),
		.en_s2 (1'b1),
		.ms    (ilnch_pkg::MS_W'(burn_time_q)),
		.ticks (burn_ticks)
	);

	ilnch_ms2tick #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_hold_conv (
		.clk   (clk),
		.en_s1 (1'b1),
		.en_s2 (1'b1),
		.ms    (ilnch_pkg::MS_W'(holdoff_q)),
		.ticks (hold_ticks)
	);

	ilnch_state u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (mv5),
		.ctl         (ctl_s5),
		.fire_now    (now_s5),
		.delay_ticks (delay_ticks),
		.burn_ticks  (burn_ticks),
		.hold_ticks  (hold_ticks),
		.result_q    (result)
	);

	assign out_valid         = out_valid_q;
	assign igniter_drive     = result.igniter_drive;
	assign nitrogen_valve    = result.nitrogen_valve;
	assign nitrous_valve     = result.nitrous_valve;
	assign retract_done_flag = result.retract_done_flag;
	assign stepper_run       = result.stepper_run;
	assign sequence_active   = result.sequence_active;
	assign holdoff_active    = result.holdoff_active;
	assign safe_off_event    = result.safe_off_event;

endmodule

### rtl/core/ilnch_checker.sv
// Port-level checks for the igniter launch sequencer, bound to the top level.
// Sees only the top level's ports; no package dependency.

module ilnch_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic igniter_drive,
	input logic nitrogen_valve,
	input logic nitrous_valve,
	input logic retract_done_flag,
	input logic stepper_run,
	input logic sequence_active,
	input logic holdoff_active,
	input logic safe_off_event
);

	// No result is offered while reset is applied.
	a_no_out_in_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	// A stalled result transfer holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({igniter_drive, nitrogen_valve,
		nitrous_valve, retract_done_flag, stepper_run, sequence_active, holdoff_active,
		safe_off_event}))
		else $error("stalled result changed");

	// A safe-off result shows every drive and timer off.
	a_safe_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && safe_off_event |-> !igniter_drive && !nitrogen_valve &&
		!nitrous_valve && !stepper_run && !sequence_active && !holdoff_active)
		else $error("drive left on in safe-off result");

	// A sequence and its restart holdoff never overlap.
	a_seq_hold_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(sequence_active && holdoff_active))
		else $error("sequence and holdoff active together");

	// A running retract move implies the retract was commanded.
	a_run_needs_retract: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stepper_run |-> retract_done_flag)
		else $error("stepper running without retract flag");

endmodule

bind igniter_launch_sequencer ilnch_checker u_ilnch_checker (.*);
